/* sv/nqb_pkg.sv */
// Package for the n-queens backtracking solver.
// Holds board constants, the diagonal/column mask struct and the controller states.
// No dependencies.
package nqb_pkg;

    localparam int MAX_SIZE = 8;
    localparam int COL_W    = 3;
    localparam int ROW_W    = 3;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int CFG_W    = 4;
    localparam logic [CFG_W-1:0] BOARD_RESET = CFG_W'(8);

    // attack masks handed from one row cell to the next
    typedef struct packed {
        logic [MAX_SIZE-1:0] cols;
        logic [MAX_SIZE-1:0] left_diag;
        logic [MAX_SIZE-1:0] right_diag;
    } t_masks;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT,
        S_NONE
    } t_state;

endpackage

/* sv/nqb_cell.sv */
// One row cell of the queen chain: stores the queen column of its row and adds
// its attacks to the masks passed down the chain. Depends on nqb_pkg.
module nqb_cell (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [nqb_pkg::COL_W-1:0] i_col_wr,
    input  logic                   i_active,
    input  nqb_pkg::t_masks        i_masks,
    output nqb_pkg::t_masks        o_masks,
    output logic [nqb_pkg::COL_W-1:0] o_col
);
    import nqb_pkg::*;

    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [MAX_SIZE-1:0] queen_bit;

    always_comb begin
        n_col = i_we ? i_col_wr : r_col;
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    always_comb begin
        queen_bit = '0;
        if (i_active) begin
            queen_bit[r_col] = 1'b1;
        end
    end

    // diagonals move one column per row going down the chain
    assign o_masks.cols       = i_masks.cols | queen_bit;
    assign o_masks.left_diag  = (i_masks.left_diag | queen_bit) << 1;
    assign o_masks.right_diag = (i_masks.right_diag | queen_bit) >> 1;
    assign o_col              = r_col;

endmodule

/* sv/n_queens_backtrack_solver.sv */
// Top level of the n-queens backtracking solver: controller, row cell chain,
// output register. Depends on nqb_pkg and nqb_cell.
//
// Usage:
//   Input channel (i_valid/o_ready) carries the column of the row-zero queen.
//   Output channel (o_valid/i_ready) returns the first solution, one transfer
//   per row in row order, o_last on the final row. With no solution (or a
//   start column off the board) a single transfer with o_found low, row and
//   column zero and o_last high is returned.
//   i_cfg_we/i_cfg_data write the board size; 0 acts as 1, above 8 acts as 8.
//   Write it only while the block is idle.
// Timing:
//   Each placement or backtrack step of the search is decided by a combinational
//   compare over the cell chain and registered in the row and column
//   registers. Result rows then go out in row order while the
//   receiver takes them. A new query is taken once the previous query's last
//   result is in the output register.
// Reset (synchronous, i_rst_n low) returns to idle with board size 8 and no
// pending result. A stalled receiver holds the output register and the
// controller waits to emit its next result.
module n_queens_backtrack_solver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nqb_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [nqb_pkg::COL_W-1:0]   i_start_column,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [nqb_pkg::ROW_W-1:0]   o_row_index,
    output logic [nqb_pkg::COL_W-1:0]   o_queen_column,
    output logic                        o_last
);
    import nqb_pkg::*;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_board_size;
    logic [SIZE_W-1:0]  r_row, n_row;
    logic [SIZE_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]   r_k, n_k;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic               r_out_last, n_out_last;

    logic [SIZE_W-1:0]   size_eff;
    logic                in_xfer, out_free;
    t_masks              taps [MAX_SIZE+1];
    logic [COL_W-1:0]    cell_cols [MAX_SIZE];
    logic [MAX_SIZE-1:0] cell_we;
    logic [MAX_SIZE-1:0] cell_active;
    logic [COL_W-1:0]    wr_col;
    logic [ROW_W-1:0]    rd_addr;
    logic [COL_W-1:0]    rd_col;
    logic [MAX_SIZE-1:0] free_cols;
    logic                any_free;
    logic [COL_W-1:0]    low_free;
    logic                place;
    logic [SIZE_W-1:0]   row_back;

    always_comb begin
        if (r_board_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_board_size > CFG_W'(MAX_SIZE)) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = SIZE_W'(r_board_size);
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // chain of row cells
    assign taps[0] = '0;
    genvar g;
    generate
        for (g = 0; g < MAX_SIZE; g++) begin : g_cell
            assign cell_active[g] = (SIZE_W'(g) < r_row);
            nqb_cell u_cell (
                .i_clk    (i_clk),
                .i_we     (cell_we[g]),
                .i_col_wr (wr_col),
                .i_active (cell_active[g]),
                .i_masks  (taps[g]),
                .o_masks  (taps[g+1]),
                .o_col    (cell_cols[g])
            );
        end
    endgenerate

    // candidate columns: unattacked, at or above the resume column, on the board
    always_comb begin
        t_masks att;
        att = taps[r_row];
        for (int c = 0; c < MAX_SIZE; c++) begin
            free_cols[c] = !(att.cols[c] || att.left_diag[c] || att.right_diag[c])
                           && (SIZE_W'(c) >= r_col) && (SIZE_W'(c) < size_eff);
        end
        any_free = |free_cols;
        low_free = '0;
        for (int c = MAX_SIZE - 1; c >= 0; c--) begin
            if (free_cols[c]) begin
                low_free = COL_W'(c);
            end
        end
    end

    assign row_back = r_row - SIZE_W'(1);
    assign rd_addr  = (r_state == S_EMIT) ? r_k : ROW_W'(row_back);
    assign rd_col   = cell_cols[rd_addr];
    assign place    = (r_state == S_SEARCH) && (r_row != size_eff) && any_free;
    assign wr_col   = (r_state == S_IDLE) ? i_start_column : low_free;

    always_comb begin
        for (int r = 0; r < MAX_SIZE; r++) begin
            cell_we[r] = place && (r_row == SIZE_W'(r));
        end
        if (in_xfer) begin
            cell_we[0] = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (SIZE_W'(i_start_column) >= size_eff) begin
                        n_row   = '0;
                        n_state = S_NONE;
                    end else begin
                        n_row   = SIZE_W'(1);
                        n_col   = '0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_row == size_eff) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else if (any_free) begin
                    n_row = r_row + SIZE_W'(1);
                    n_col = '0;
                end else begin
                    // backtrack: resume the previous row past its queen
                    n_row = row_back;
                    n_col = SIZE_W'(rd_col) + SIZE_W'(1);
                    if (row_back == '0) begin
                        n_state = S_NONE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_row   = r_k;
                    n_out_col   = rd_col;
                    n_out_last  = (SIZE_W'(r_k) + SIZE_W'(1) == size_eff);
                    n_k         = r_k + ROW_W'(1);
                    if (SIZE_W'(r_k) + SIZE_W'(1) == size_eff) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_row   = '0;
                    n_out_col   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_board_size <= BOARD_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_board_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out_found;
    assign o_row_index    = r_out_row;
    assign o_queen_column = r_out_col;
    assign o_last         = r_out_last;

endmodule

/* tb/sv/queens_checker.sv */
// Checker for the n-queens backtracking solver: tracks the board size register,
// predicts the first solution of each query and compares every result transfer.
// Depends on nqb_pkg.
`timescale 1ns / 100ps
module queens_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nqb_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [nqb_pkg::COL_W-1:0] i_start_column,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_found,
    input  logic [nqb_pkg::ROW_W-1:0] i_row_index,
    input  logic [nqb_pkg::COL_W-1:0] i_queen_column,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_queries,
    output int                        o_solved,
    output int                        o_rows
);
    import nqb_pkg::*;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_placement;

    t_placement       solution_q[$];
    logic [CFG_W-1:0] r_board_size;

    always @(posedge i_clk) begin : watch
        logic [COL_W-1:0] placed [MAX_SIZE];
        t_placement       want;
        t_placement       got;
        int               n;
        int               row;
        int               c;
        int               r;
        int               pc;
        bit               ok;
        bit               clash;
        bit               hit;

        if (!i_rst_n) begin
            r_board_size <= BOARD_RESET;
            solution_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
            o_queries    <= 0;
            o_solved     <= 0;
            o_rows       <= 0;
        end else begin
            if (i_cfg_we) begin
                r_board_size <= i_cfg_data;
            end

            if (i_in_valid && i_in_ready) begin
                // zero acts as one, anything above the board limit saturates
                n = int'(r_board_size);
                if (n == 0) n = 1;
                if (n > MAX_SIZE) n = MAX_SIZE;
                ok = 1'b0;
                if (int'(i_start_column) < n) begin
                    placed[0] = i_start_column;
                    row = 1;
                    c = 0;
                    while (row < n) begin
                        hit = 1'b0;
                        while (c < n && !hit) begin
                            clash = 1'b0;
                            for (r = 0; r < row; r++) begin
                                pc = int'(placed[r]);
                                if (pc == c || (pc > c ? pc - c : c - pc) == row - r) begin
                                    clash = 1'b1;
                                end
                            end
                            if (clash) c++;
                            else hit = 1'b1;
                        end
                        if (hit) begin
                            placed[row] = COL_W'(c);
                            row++;
                            c = 0;
                        end else begin
                            // backtrack: resume one column past the previous queen
                            row--;
                            if (row == 0) break;
                            c = int'(placed[row]) + 1;
                        end
                    end
                    ok = (row == n);
                end
                if (!ok) begin
                    solution_q.push_back('{found: 1'b0, row: '0, col: '0, last: 1'b1});
                end else begin
                    for (r = 0; r < n; r++) begin
                        solution_q.push_back('{found: 1'b1, row: ROW_W'(r), col: placed[r],
                                               last: (r == n - 1)});
                    end
                end
                o_queries <= o_queries + 1;
                o_solved  <= o_solved + int'(ok);
            end

            if (i_out_valid && i_out_ready) begin
                got = '{found: i_found, row: i_row_index, col: i_queen_column, last: i_last};
                if (solution_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected result found=%0d row=%0d col=%0d last=%0d",
                                 $realtime, got.found, got.row, got.col, got.last);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = solution_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: expected found=%0d row=%0d col=%0d last=%0d",
                                     $realtime, want.found, want.row, want.col, want.last);
                            $display("%0t:   actual found=%0d row=%0d col=%0d last=%0d",
                                     $realtime, got.found, got.row, got.col, got.last);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                    o_rows <= o_rows + 1;
                end
            end

            o_pending <= solution_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the n-queens solver testbench: clock, reset, board size writes and
// query traffic with random idling. Depends on nqb_pkg, queens_checker and the solver.
`timescale 1ns / 100ps
module tb_top;
    import nqb_pkg::*;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_valid        = 1'b0;
    logic [COL_W-1:0] i_start_column = '0;
    logic             i_ready        = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic             o_found;
    logic [ROW_W-1:0] o_row_index;
    logic [COL_W-1:0] o_queen_column;
    logic             o_last;

    int fail_count;
    int pending;
    int queries;
    int solved;
    int rows;
    int tx_idle     = 17;
    int rx_idle     = 46;
    int board_count = 0;
    bit pressure_go = 1'b0;
    logic rx_hold   = 1'b0;

    n_queens_backtrack_solver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_column (i_start_column),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_row_index    (o_row_index),
        .o_queen_column (o_queen_column),
        .o_last         (o_last)
    );

    queens_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_start_column (i_start_column),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_found        (o_found),
        .i_row_index    (o_row_index),
        .i_queen_column (o_queen_column),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_queries      (queries),
        .o_solved       (solved),
        .o_rows         (rows)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);
    end

    // long receiver hold-off: lets the solver fill up and stall its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #40_000_000;
        $display("n_queens_backtrack_solver test failed");
        $finish;
    end

    task automatic send_query(input int col);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_start_column <= COL_W'(col);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid, wait for every expected row, then let the block go idle
    task automatic settle(input int tail);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic set_board(input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board_count++;
    endtask

    initial begin
        int directed_sizes [6] = '{0, 2, 3, 4, 6, 15};
        int directed_cols [3]  = '{0, 1, 7};
        int value;
        int eff;
        int col;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset board size: every start column
        for (int s = 0; s < 8; s++) send_query(s);
        foreach (directed_sizes[i]) begin
            settle(8);
            set_board(directed_sizes[i]);
            foreach (directed_cols[j]) send_query(directed_cols[j]);
        end

        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin tx_idle = 17; rx_idle = 46; end
                1: begin tx_idle = 46; rx_idle = 17; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            case (p)
                0: value = 8;
                1: value = 1;
                2: value = 15;
                3: value = 0;
                8: value = 8;
                default: value = $urandom_range(0, 15);
            endcase
            eff = (value == 0) ? 1 : (value > MAX_SIZE ? MAX_SIZE : value);
            settle(8);
            set_board(value);
            if (p == 8) pressure_go = 1'b1;
            repeat (18) begin
                // mostly on-board start columns, some off the board
                if ($urandom_range(0, 3) != 0) col = $urandom_range(0, eff - 1);
                else col = $urandom_range(0, 7);
                send_query(col);
            end
        end

        settle(20);
        $display("ran %0d queries over %0d board size writes plus the reset size;",
                 queries, board_count);
        $display("%0d queries had a solution, %0d result rows compared", solved, rows);
        if (fail_count == 0) begin
            $display("n_queens_backtrack_solver test passed");
        end else begin
            $display("n_queens_backtrack_solver test failed");
        end
        $finish;
    end

endmodule
